/* rtl/core/sgd_pkg.sv */
// Shared types, widths and codes for the Sobel gradient direction core.
package sgd_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int HEIGHT_CAP        = 1024;
   localparam int MIN_SIZE          = 3;

   localparam int CHAN_W   = 8;
   localparam int SUM_W    = 10;
   localparam int ROW_W    = 10;
   localparam int SIZE_W   = 11;
   localparam int GRAD_W   = 13;
   localparam int ABS_W    = 12;
   localparam int MAG_W    = 13;
   localparam int DIR_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [DIR_W-1:0] DIR_0   = 2'd0;
   localparam logic [DIR_W-1:0] DIR_45  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_90  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_135 = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } sgd_req_type;

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic [DIR_W-1:0] orientation;
      logic             last_of_frame;
   } sgd_rsp_type;

endpackage

/* rtl/core/sgd_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module sgd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/sobel_gradient_direction_core.sv */
// Sobel gradient magnitude and quantized direction over an RGB raster stream.
// A result for an interior pixel passes through the stage 1, window, gradient, square and output registers.
// Throughput: one pixel per clock while req_stall is low; the line memory is read and written back in each such cycle.
// A one-entry skid stage behind the output register holds a result while rsp_stall is high.
// Reset clears counters and valid flags and sets the size registers to 640 x 480; line memory
// contents stay undefined until written, with no clearing pass.
module sobel_gradient_direction_core #(
   parameter int MAX_WIDTH = sgd_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sgd_pkg::sgd_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sgd_pkg::sgd_rsp_type              rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sgd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sgd_pkg::SIZE_W-1:0]        csr_data
);
   import sgd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int XW = (CW + 1 > SIZE_W + 1) ? CW + 1 : SIZE_W + 1;
   localparam int LW = 2 * SUM_W;
   localparam int SQ_W = 2 * MAG_W;
   localparam int AX2_W = 2 * ABS_W + 1;

   // configuration and counters
   logic [SIZE_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [XW-1:0]     width_lim;
   logic [SIZE_W-1:0] height_lim;
   logic              col_end, row_end, csr_write, req_take, en;

   // stage 1: line memory read in flight
   logic              s1_valid_ff, s1_interior_ff, s1_last_ff;
   logic [SUM_W-1:0]  s1_sum_ff, sum_in;
   logic [CW-1:0]     s1_col_ff;
   logic [LW-1:0]     line_rd;

   // stage 2: window
   logic              s2_valid_ff, s2_interior_ff, s2_last_ff;
   logic [SUM_W-1:0]  win_ff [9];
   logic [SUM_W-1:0]  win_in [9];

   // stage 3: gradient magnitudes
   logic signed [GRAD_W-1:0] gx, gy;
   logic              s3_valid_ff, s3_last_ff, s3_same_ff;
   logic [ABS_W-1:0]  s3_ax_ff, s3_ay_ff, ax_in, ay_in;
   logic [MAG_W-1:0]  s3_mag_ff, mag_in;

   // stage 4: squares
   logic              s4_valid_ff, s4_last_ff, s4_same_ff;
   logic              s4_ay_zero_ff, s4_ax_zero_ff, s4_ay_le_ax_ff;
   logic [MAG_W-1:0]  s4_mag_ff, abs_sum;
   logic [SQ_W-1:0]   s4_sum_sq_ff, sum_sq_in;
   logic [AX2_W-1:0]  s4_two_ax2_ff, two_ax2_in;
   logic [2*ABS_W-1:0] s4_diff_sq_ff, diff_sq_in, ax_sq;
   logic [ABS_W-1:0]  abs_diff;

   // output register and skid stage
   logic              below_low, below_high, new_item, rsp_take;
   logic [DIR_W-1:0]  dir_in;
   sgd_rsp_type       result;
   logic              out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   sgd_rsp_type       out_data_ff, out_data_in, skid_data_ff, skid_data_in;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && en;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && (csr_index == CSR_IMAGE_WIDTH ||
                                    csr_index == CSR_IMAGE_HEIGHT);

   always_comb begin
      if (width_ff < SIZE_W'(MIN_SIZE)) begin
         width_lim = XW'(MIN_SIZE);
      end else if (XW'(width_ff) > XW'(MAX_WIDTH)) begin
         width_lim = XW'(MAX_WIDTH);
      end else begin
         width_lim = XW'(width_ff);
      end
      if (height_ff < SIZE_W'(MIN_SIZE)) begin
         height_lim = SIZE_W'(MIN_SIZE);
      end else if (height_ff > SIZE_W'(HEIGHT_CAP)) begin
         height_lim = SIZE_W'(HEIGHT_CAP);
      end else begin
         height_lim = height_ff;
      end
   end

   assign col_end = (XW'(col_ff) + XW'(1)) >= width_lim;
   assign row_end = (SIZE_W'(row_ff) + SIZE_W'(1)) >= height_lim;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_write) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            width_in = csr_data;
         end else begin
            height_in = csr_data;
         end
         col_in = '0;
         row_in = '0;
      end else if (req_take) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   assign sum_in = SUM_W'(req_data.red) + SUM_W'(req_data.green) + SUM_W'(req_data.blue);

   sgd_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (en && s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({line_rd[SUM_W-1:0], s1_sum_ff}),
      .rd_en   (req_take),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]     = win_ff[k*3 + 1];
         win_in[k*3 + 1] = win_ff[k*3 + 2];
      end
      win_in[2] = line_rd[LW-1:SUM_W];
      win_in[5] = line_rd[SUM_W-1:0];
      win_in[8] = s1_sum_ff;
   end

   always_comb begin
      gx = ($signed(GRAD_W'(win_ff[2])) - $signed(GRAD_W'(win_ff[0])))
         + (($signed(GRAD_W'(win_ff[5])) - $signed(GRAD_W'(win_ff[3]))) <<< 1)
         + ($signed(GRAD_W'(win_ff[8])) - $signed(GRAD_W'(win_ff[6])));
      gy = ($signed(GRAD_W'(win_ff[6])) + ($signed(GRAD_W'(win_ff[7])) <<< 1)
            + $signed(GRAD_W'(win_ff[8])))
         - ($signed(GRAD_W'(win_ff[0])) + ($signed(GRAD_W'(win_ff[1])) <<< 1)
            + $signed(GRAD_W'(win_ff[2])));
      ax_in  = gx[GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
      ay_in  = gy[GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);
      mag_in = MAG_W'(ax_in) + MAG_W'(ay_in);
   end

   always_comb begin
      abs_sum    = MAG_W'(s3_ax_ff) + MAG_W'(s3_ay_ff);
      abs_diff   = s3_ay_ff - s3_ax_ff;
      sum_sq_in  = abs_sum * abs_sum;
      ax_sq      = s3_ax_ff * s3_ax_ff;
      two_ax2_in = {ax_sq, 1'b0};
      diff_sq_in = abs_diff * abs_diff;
   end

   always_comb begin
      below_low  = s4_sum_sq_ff < SQ_W'(s4_two_ax2_ff);
      below_high = s4_ay_le_ax_ff || (AX2_W'(s4_diff_sq_ff) < s4_two_ax2_ff);
      if (s4_ay_zero_ff) begin
         dir_in = DIR_0;
      end else if (s4_ax_zero_ff) begin
         dir_in = DIR_90;
      end else if (below_low) begin
         dir_in = DIR_0;
      end else if (below_high) begin
         dir_in = s4_same_ff ? DIR_45 : DIR_135;
      end else begin
         dir_in = DIR_90;
      end
      result.magnitude     = s4_mag_ff;
      result.orientation   = dir_in;
      result.last_of_frame = s4_last_ff;
   end

   assign new_item = en && s4_valid_ff;
   assign rsp_take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (new_item) begin
            out_data_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (!out_valid_ff) begin
         if (new_item) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end
      end else if (new_item) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= SIZE_W'(WIDTH_RESET);
         height_ff     <= SIZE_W'(HEIGHT_RESET);
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (en) begin
            s1_valid_ff <= req_take;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff && s2_interior_ff;
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
      if (en) begin
         s1_sum_ff      <= sum_in;
         s1_col_ff      <= col_ff;
         s1_interior_ff <= (row_ff >= ROW_W'(2)) && (col_ff >= CW'(2));
         s1_last_ff     <= row_end && col_end;
         s2_interior_ff <= s1_interior_ff;
         s2_last_ff     <= s1_last_ff;
         s3_ax_ff       <= ax_in;
         s3_ay_ff       <= ay_in;
         s3_mag_ff      <= mag_in;
         s3_same_ff     <= gx[GRAD_W-1] == gy[GRAD_W-1];
         s3_last_ff     <= s2_last_ff;
         s4_sum_sq_ff   <= sum_sq_in;
         s4_two_ax2_ff  <= two_ax2_in;
         s4_diff_sq_ff  <= diff_sq_in;
         s4_ay_le_ax_ff <= s3_ay_ff <= s3_ax_ff;
         s4_ay_zero_ff  <= s3_ay_ff == '0;
         s4_ax_zero_ff  <= s3_ax_ff == '0;
         s4_mag_ff      <= s3_mag_ff;
         s4_same_ff     <= s3_same_ff;
         s4_last_ff     <= s3_last_ff;
         if (s1_valid_ff) begin
            win_ff <= win_in;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
